@@ hdl/kclc_pkg.sv @@
// Package for the keypad code lock controller: widths, key and status codes,
// the result record passed between stages and the reset code.
// No dependencies; every other file refers to it by scoped names.
package kclc_pkg;

    localparam int CODE_LENGTH = 3;
    localparam int POS_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int KEY_W       = 4;
    localparam int TRIES_W     = 4;
    localparam int STATUS_W    = 4;

    localparam logic [KEY_W-1:0]   KEY_STAR          = 4'd10;
    localparam logic [KEY_W-1:0]   RESET_FIRST_DIGIT = 4'd2;
    localparam logic [KEY_W-1:0]   RESET_OTHER_DIGIT = 4'd0;
    localparam logic [TRIES_W-1:0] TRIES_RESET       = 4'd3;
    localparam logic [TRIES_W-1:0] MAX_TRIES_RESET   = 4'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN     = 4'd0,
        ST_UNLOCKED  = 4'd1,
        ST_LOCKED    = 4'd2,
        ST_WRONG     = 4'd3,
        ST_ALARM     = 4'd4,
        ST_ENTER_NEW = 4'd5,
        ST_CONFIRM   = 4'd6,
        ST_UPDATED   = 4'd7,
        ST_MISMATCH  = 4'd8
    } status_t;

    typedef struct packed {
        status_t             status;
        logic                relay_on;
        logic [TRIES_W-1:0]  tries_left;
        logic [KEY_W-1:0]    echo_key;
    } result_t;

endpackage

@@ hdl/kclc_in_stage.sv @@
// Input register of the keypad code lock controller: holds one key and
// releases it when the result register can take the outcome.
// Depends on kclc_pkg.
module kclc_in_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [kclc_pkg::KEY_W-1:0] key_code,
    input  logic                      down_ready,
    output logic                      fire,
    output logic [kclc_pkg::KEY_W-1:0] key
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [kclc_pkg::KEY_W-1:0] key_reg;
    logic                       load;

    assign in_stall = valid_reg && !down_ready;
    assign load     = in_valid && !in_stall;
    assign fire     = valid_reg && down_ready;
    assign key      = key_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= key_code;
        end
    end

endmodule

@@ hdl/kclc_lock_fsm.sv @@
// Lock state machine: entry position, mode, code buffers, stored code,
// try counter and relay; computes the outcome of one key in a single pass.
// Depends on kclc_pkg.
module kclc_lock_fsm
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [kclc_pkg::KEY_W-1:0]    key,
    input  logic [kclc_pkg::TRIES_W-1:0]  max_tries,
    output kclc_pkg::result_t             result
);

    typedef enum logic [1:0] {
        MODE_ENTRY   = 2'd0,
        MODE_NEW     = 2'd1,
        MODE_CONFIRM = 2'd2
    } mode_t;

    localparam logic [kclc_pkg::POS_W-1:0] LAST_POS =
        kclc_pkg::POS_W'(kclc_pkg::CODE_LENGTH - 1);

    mode_t                           mode_reg;
    mode_t                           mode_next;
    logic [kclc_pkg::POS_W-1:0]      pos_reg;
    logic [kclc_pkg::POS_W-1:0]      pos_next;
    logic [kclc_pkg::POS_W-1:0]      pos_inc;
    logic                            relay_reg;
    logic                            relay_next;
    logic [kclc_pkg::TRIES_W-1:0]    tries_reg;
    logic [kclc_pkg::TRIES_W-1:0]    tries_next;
    logic [kclc_pkg::KEY_W-1:0]      entry_buffer_reg [kclc_pkg::CODE_LENGTH];
    logic [kclc_pkg::KEY_W-1:0]      new_code_reg     [kclc_pkg::CODE_LENGTH];
    logic [kclc_pkg::KEY_W-1:0]      stored_code_reg  [kclc_pkg::CODE_LENGTH];
    logic [kclc_pkg::KEY_W-1:0]      merged           [kclc_pkg::CODE_LENGTH];
    logic                            last;
    logic                            match_stored;
    logic                            match_new;
    logic                            entry_we;
    logic                            new_we;
    logic                            store_we;
    kclc_pkg::status_t               status;

    assign last    = (pos_reg == LAST_POS);
    assign pos_inc = last ? '0 : pos_reg + 1'b1;

    // Entry as it stands once the current key is in place
    always_comb
    begin
        match_stored = 1'b1;
        match_new    = 1'b1;
        for (int k = 0; k < kclc_pkg::CODE_LENGTH; k++)
        begin
            merged[k] = (pos_reg == kclc_pkg::POS_W'(k)) ? key : entry_buffer_reg[k];
            if (merged[k] != stored_code_reg[k])
            begin
                match_stored = 1'b0;
            end
            if (merged[k] != new_code_reg[k])
            begin
                match_new = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        relay_next = relay_reg;
        tries_next = tries_reg;
        status     = kclc_pkg::ST_TAKEN;
        entry_we   = 1'b0;
        new_we     = 1'b0;
        store_we   = 1'b0;
        case (mode_reg)
            MODE_NEW:
            begin
                new_we   = 1'b1;
                pos_next = pos_inc;
                if (last)
                begin
                    mode_next = MODE_CONFIRM;
                    status    = kclc_pkg::ST_CONFIRM;
                end
            end
            MODE_CONFIRM:
            begin
                entry_we = 1'b1;
                pos_next = pos_inc;
                if (last)
                begin
                    if (match_new)
                    begin
                        store_we   = 1'b1;
                        tries_next = max_tries;
                        mode_next  = MODE_ENTRY;
                        status     = kclc_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        mode_next = MODE_NEW;
                        status    = kclc_pkg::ST_MISMATCH;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_ENTRY;
                if (pos_reg == '0 && key == kclc_pkg::KEY_STAR)
                begin
                    mode_next = MODE_NEW;
                    status    = kclc_pkg::ST_ENTER_NEW;
                end
                else
                begin
                    entry_we = 1'b1;
                    pos_next = pos_inc;
                    if (last)
                    begin
                        if (match_stored)
                        begin
                            status     = relay_reg ? kclc_pkg::ST_UNLOCKED
                                                   : kclc_pkg::ST_LOCKED;
                            relay_next = !relay_reg;
                            tries_next = max_tries;
                        end
                        else if (tries_reg <= kclc_pkg::TRIES_W'(1))
                        begin
                            status     = kclc_pkg::ST_ALARM;
                            tries_next = max_tries;
                        end
                        else
                        begin
                            status     = kclc_pkg::ST_WRONG;
                            tries_next = tries_reg - 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    assign result.status     = status;
    assign result.relay_on   = relay_next;
    assign result.tries_left = tries_next;
    assign result.echo_key   = key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENTRY;
            pos_reg   <= '0;
            relay_reg <= 1'b0;
            tries_reg <= kclc_pkg::TRIES_RESET;
            for (int k = 0; k < kclc_pkg::CODE_LENGTH; k++)
            begin
                stored_code_reg[k] <= (k == 0) ? kclc_pkg::RESET_FIRST_DIGIT
                                               : kclc_pkg::RESET_OTHER_DIGIT;
            end
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            relay_reg <= relay_next;
            tries_reg <= tries_next;
            if (store_we)
            begin
                for (int k = 0; k < kclc_pkg::CODE_LENGTH; k++)
                begin
                    stored_code_reg[k] <= new_code_reg[k];
                end
            end
        end
    end

    // Code buffers have no reset; every entry is written before it is compared
    always_ff @(posedge clk)
    begin
        if (fire && entry_we)
        begin
            entry_buffer_reg[pos_reg] <= key;
        end
        if (fire && new_we)
        begin
            new_code_reg[pos_reg] <= key;
        end
    end

endmodule

@@ hdl/kclc_out_stage.sv @@
// Result register of the keypad code lock controller: holds one result
// transaction until the receiver takes it.
// Depends on kclc_pkg.
module kclc_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  kclc_pkg::result_t result,
    output logic              up_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output kclc_pkg::result_t out_result
);

    logic              valid_reg;
    kclc_pkg::result_t result_reg;

    assign up_ready   = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ hdl/keypad_code_lock_controller_core.sv @@
// Top level of the keypad code lock controller: input register, lock state
// machine, result register and the max_tries configuration register.
// Depends on kclc_pkg, kclc_in_stage, kclc_lock_fsm and kclc_out_stage.
//
// Usage:
//   Input channel (in_valid, in_stall, key_code) carries one decoded key per
//   transaction: 0-9 digits, 10 star, 11 hash. Output channel (out_valid,
//   out_stall, status, relay_on, tries_left, echo_key) returns exactly one
//   result transaction per key, in order.
//   Path: a key accepted into the input register moves on, with its result,
//   into the result register, where the receiver can take it; a stall can
//   hold it in either register.
//   Throughput: one key per cycle while out_stall is low; the whole per-key
//   update is a single pass of logic between the input and result registers.
//   Stall: while the result register holds an untaken result and out_stall
//   is high, the input register holds its key and in_stall rises once it is
//   full; state advances only when a result moves into the result register.
//   Configuration: cfg_valid/cfg_ready/cfg_data write max_tries (ready is
//   always high). Write it only while no key is in flight; the try counter
//   picks it up at its next refill.
//   Reset (rst_n low, asynchronous): both registers empty, code entry mode,
//   position zero, stored code 2-0-0, three tries, relay off, max_tries 3.
module keypad_code_lock_controller_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kclc_pkg::KEY_W-1:0]    key_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kclc_pkg::STATUS_W-1:0] status,
    output logic                          relay_on,
    output logic [kclc_pkg::TRIES_W-1:0]  tries_left,
    output logic [kclc_pkg::KEY_W-1:0]    echo_key,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kclc_pkg::TRIES_W-1:0]  cfg_data
);

    logic                          cfg_write;
    logic [kclc_pkg::TRIES_W-1:0]  max_tries_reg;
    logic                          fire;
    logic                          down_ready;
    logic [kclc_pkg::KEY_W-1:0]    key;
    kclc_pkg::result_t             result;
    kclc_pkg::result_t             out_result;

    // Configuration register; always ready. Writes must arrive only when idle; the block does not enforce it
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tries_reg <= kclc_pkg::MAX_TRIES_RESET;
        end
        else if (cfg_write)
        begin
            max_tries_reg <= cfg_data;
        end
    end

    // Hold the key until the result register can take its outcome
    kclc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_code   (key_code),
        .down_ready (down_ready),
        .fire       (fire),
        .key        (key)
    );

    // Advance the lock state once per released key
    kclc_lock_fsm u_lock_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .key       (key),
        .max_tries (max_tries_reg),
        .result    (result)
    );

    // Hold each result transaction until the receiver takes it
    kclc_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .result     (result),
        .up_ready   (down_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign status     = out_result.status;
    assign relay_on   = out_result.relay_on;
    assign tries_left = out_result.tries_left;
    assign echo_key   = out_result.echo_key;

endmodule

@@ hdl/kclc_checker.sv @@
// Port-level checker for the keypad code lock controller and its bind.
// Depends on kclc_pkg and keypad_code_lock_controller_core.
module kclc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [kclc_pkg::STATUS_W-1:0] status,
    input logic                          relay_on,
    input logic [kclc_pkg::TRIES_W-1:0]  tries_left,
    input logic [kclc_pkg::KEY_W-1:0]    echo_key
);

    // A stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(relay_on)
            && $stable(tries_left) && $stable(echo_key))
        else $error("stalled result changed");

    // Unlocking leaves the relay off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == kclc_pkg::ST_UNLOCKED |-> !relay_on)
        else $error("unlocked with relay on");

    // Locking leaves the relay on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == kclc_pkg::ST_LOCKED |-> relay_on)
        else $error("locked with relay off");

    // A wrong code never drains the counter; that case raises the alarm
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == kclc_pkg::ST_WRONG |-> tries_left != '0)
        else $error("wrong code left zero tries");

endmodule

bind keypad_code_lock_controller_core kclc_checker u_kclc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .relay_on   (relay_on),
    .tries_left (tries_left),
    .echo_key   (echo_key)
);

@@ sim/keypad_code_lock_controller_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keypad_code_lock_controller_core: drives keys and
// max_tries writes, predicts every result and checks each output transaction.
// Depends on kclc_pkg and the controller RTL only.
module keypad_code_lock_controller_core_test;

    localparam int IDLE_PCT      = 35;  // chance of a gap or stall per cycle
    localparam int MAX_SHOWN     = 10;  // mismatches printed in full
    localparam int SETTLE_CYCLES = 6;   // covers the two register stages plus margin

    localparam logic [kclc_pkg::KEY_W-1:0] KEY_HASH = 4'd11;

    typedef enum logic [1:0] {
        MODE_ENTRY   = 2'd0,
        MODE_NEW     = 2'd1,
        MODE_CONFIRM = 2'd2
    } lock_mode_t;

    typedef logic [kclc_pkg::CODE_LENGTH-1:0][kclc_pkg::KEY_W-1:0] code_t;

    // DUT connections, all inputs known from time zero
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [kclc_pkg::KEY_W-1:0]     key_code   = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic [kclc_pkg::STATUS_W-1:0]  status;
    logic                           relay_on;
    logic [kclc_pkg::TRIES_W-1:0]   tries_left;
    logic [kclc_pkg::KEY_W-1:0]     echo_key;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [kclc_pkg::TRIES_W-1:0]   cfg_data   = '0;

    // Lock state as the testbench expects it to be after the last accepted key
    lock_mode_t                     lock_mode;
    int                             lock_pos;
    code_t                          entry_keys;
    code_t                          new_code;
    code_t                          stored_code;
    logic [kclc_pkg::TRIES_W-1:0]   tries_count;
    logic [kclc_pkg::TRIES_W-1:0]   tries_limit;
    logic                           relay_state;

    kclc_pkg::result_t              pending_results[$];
    int                             fault_count = 0;
    int                             keys_sent   = 0;
    bit                             no_gaps     = 1'b0;

    keypad_code_lock_controller_core uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_code   (key_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .relay_on   (relay_on),
        .tries_left (tries_left),
        .echo_key   (echo_key),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("** keypad_code_lock_controller_core: FAILED **");
        $finish;
    end

    function automatic bit take_break();
        return !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Advance the expected lock state by one key and return the result it causes.
    function automatic kclc_pkg::result_t next_lock_result(
        input logic [kclc_pkg::KEY_W-1:0] key);
        kclc_pkg::result_t r;
        int                p;
        r.status = kclc_pkg::ST_TAKEN;
        p = (lock_pos >= kclc_pkg::CODE_LENGTH) ? 0 : lock_pos;
        case (lock_mode)
            MODE_NEW:
            begin
                new_code[p] = key;
                p++;
                if (p >= kclc_pkg::CODE_LENGTH)
                begin
                    p         = 0;
                    lock_mode = MODE_CONFIRM;
                    r.status  = kclc_pkg::ST_CONFIRM;
                end
            end
            MODE_CONFIRM:
            begin
                entry_keys[p] = key;
                p++;
                if (p >= kclc_pkg::CODE_LENGTH)
                begin
                    p = 0;
                    if (new_code == entry_keys)
                    begin
                        stored_code = new_code;
                        tries_count = tries_limit;
                        lock_mode   = MODE_ENTRY;
                        r.status    = kclc_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        lock_mode = MODE_NEW;
                        r.status  = kclc_pkg::ST_MISMATCH;
                    end
                end
            end
            default:
            begin
                lock_mode = MODE_ENTRY;
                if (p == 0 && key == kclc_pkg::KEY_STAR)
                begin
                    lock_mode = MODE_NEW;
                    r.status  = kclc_pkg::ST_ENTER_NEW;
                end
                else
                begin
                    entry_keys[p] = key;
                    p++;
                    if (p >= kclc_pkg::CODE_LENGTH)
                    begin
                        p = 0;
                        if (entry_keys == stored_code)
                        begin
                            r.status    = relay_state ? kclc_pkg::ST_UNLOCKED
                                                      : kclc_pkg::ST_LOCKED;
                            relay_state = ~relay_state;
                            tries_count = tries_limit;
                        end
                        else if (tries_count <= 1)
                        begin
                            r.status    = kclc_pkg::ST_ALARM;
                            tries_count = tries_limit;
                        end
                        else
                        begin
                            tries_count = tries_count - 1'b1;
                            r.status    = kclc_pkg::ST_WRONG;
                        end
                    end
                end
            end
        endcase
        lock_pos     = p;
        r.relay_on   = relay_state;
        r.tries_left = tries_count;
        r.echo_key   = key;
        return r;
    endfunction

    function automatic code_t random_code();
        code_t c;
        for (int i = 0; i < kclc_pkg::CODE_LENGTH; i++)
            c[i] = kclc_pkg::KEY_W'($urandom_range(0, 11));
        return c;
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < MAX_SHOWN)
            $display("%0t: mismatch: %s", $time, msg);
        fault_count++;
    endtask

    // Send one key transaction; hold the payload while stalled and record the
    // expected result at the accepting edge. Valid is left high so that a
    // back-to-back key needs no second assignment in the same step.
    task automatic send_key(input logic [kclc_pkg::KEY_W-1:0] key);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_code <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(next_lock_result(key));
        keys_sent++;
    endtask

    task automatic send_code(input code_t c);
        for (int i = 0; i < kclc_pkg::CODE_LENGTH; i++)
            send_key(c[i]);
    endtask

    // Drop valid and hold until every expected result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write max_tries only while nothing is in flight.
    task automatic write_max_tries(input logic [kclc_pkg::TRIES_W-1:0] limit);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        tries_limit  = limit;
    endtask

    // Finish any open entry so the next sequence starts at the first key of
    // code entry; an open change is completed with its own new code.
    task automatic realign_entry();
        while (!(lock_mode == MODE_ENTRY && lock_pos == 0))
            send_key(lock_mode == MODE_CONFIRM ? new_code[lock_pos]
                                               : kclc_pkg::KEY_W'($urandom_range(0, 9)));
    endtask

    // Reset code twice (lock then unlock), then wrong entries down to the
    // alarm, using hash first, star in a later position and the unused codes.
    task automatic test_entry_and_alarm();
        send_code(stored_code);
        send_code(stored_code);
        send_key(KEY_HASH);
        send_key(kclc_pkg::KEY_STAR);
        send_key(4'd15);
        send_key(4'd12);
        send_key(4'd13);
        send_key(4'd14);
        send_key(4'd0);
        send_key(4'd9);
        send_key(4'd0);
    endtask

    // Star as first key opens a change; a bad confirm asks for the new code
    // again, a good one replaces the stored code.
    task automatic test_code_change();
        send_key(kclc_pkg::KEY_STAR);
        send_code({4'd3, 4'd2, 4'd1});
        send_code({4'd4, 4'd2, 4'd1});
        send_code({kclc_pkg::KEY_STAR, 4'd15, KEY_HASH});
        send_code({kclc_pkg::KEY_STAR, 4'd15, KEY_HASH});
    endtask

    // Mostly well-formed sequences with random content, the rest noise keys
    // that break entries up at random positions.
    task automatic test_random_sessions(input logic [kclc_pkg::TRIES_W-1:0] limit,
                                        input int count, input bit steady);
        int    stop_at;
        int    pick;
        code_t c;
        write_max_tries(limit);
        no_gaps = steady;
        stop_at = keys_sent + count;
        while (keys_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 4))
                    send_key(kclc_pkg::KEY_W'($urandom_range(0, 15)));
            end
            else
            begin
                realign_entry();
                if (pick < 45)
                    send_code(stored_code);
                else if (pick < 70)
                    send_code(random_code());
                else
                begin
                    c = random_code();
                    send_key(kclc_pkg::KEY_STAR);
                    send_code(c);
                    send_code(pick < 85 ? c : random_code());
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver side: stall at random, never while a steady stretch runs
    always @(posedge clk)
    begin
        out_stall <= take_break();
    end

    // Compare each taken result with the oldest expected one
    always @(posedge clk)
    begin : check_results
        kclc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_fault($sformatf("unexpected result: status %0d key %0d",
                                       status, echo_key));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || relay_on !== want.relay_on ||
                    tries_left !== want.tries_left || echo_key !== want.echo_key)
                    report_fault({
                        $sformatf("expected st %0d relay %0b tries %0d key %0d",
                                  want.status, want.relay_on, want.tries_left,
                                  want.echo_key),
                        $sformatf(", got st %0d relay %0b tries %0d key %0d",
                                  status, relay_on, tries_left, echo_key)});
            end
        end
    end

    initial
    begin
        lock_mode   = MODE_ENTRY;
        lock_pos    = 0;
        entry_keys  = '0;
        new_code    = '0;
        stored_code = '0;
        stored_code[0] = kclc_pkg::RESET_FIRST_DIGIT;
        tries_count = kclc_pkg::TRIES_RESET;
        tries_limit = kclc_pkg::MAX_TRIES_RESET;
        relay_state = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_entry_and_alarm();
        test_code_change();
        test_random_sessions(4'd1, 150, 1'b0);
        test_random_sessions(4'd15, 150, 1'b0);
        test_random_sessions(kclc_pkg::TRIES_W'($urandom_range(2, 14)), 150, 1'b1);
        test_random_sessions(4'd3, 150, 1'b0);
        test_random_sessions(kclc_pkg::TRIES_W'($urandom_range(1, 15)), 150, 1'b0);

        wait_drained();
        if (fault_count == 0)
            $display("** keypad_code_lock_controller_core: PASSED **");
        else
            $display("** keypad_code_lock_controller_core: FAILED **");
        $finish;
    end

endmodule

@@ keypad_code_lock_controller_core.f @@
hdl/kclc_pkg.sv
hdl/kclc_in_stage.sv
hdl/kclc_lock_fsm.sv
hdl/kclc_out_stage.sv
hdl/keypad_code_lock_controller_core.sv
hdl/kclc_checker.sv
sim/keypad_code_lock_controller_core_test.sv
